[rtl/rvcd_pkg.sv]
package rvcd_pkg;

   localparam int DATA_IN_W  = 64;
   localparam int DATA_OUT_W = 56;

   // Held values after reset
   localparam logic [3:0] ROBOT_ID_RESET = 4'd1;
   localparam logic [3:0] DRIBBLE_RESET  = 4'd3;

   // Turn scale of 8/1000 is a division by 125: multiply by ceil(2^23/125) and shift.
   // The rounding error stays below one part in 125 for every 16-bit magnitude.
   localparam logic [16:0] TURN_RECIP = 17'd67109;
   localparam int          TURN_SHIFT = 23;

   // CORDIC gain as a 32-bit fraction
   localparam logic [31:0] CORDIC_GAIN_Q32 = 32'd2608131496;

   localparam int ATAN_LEN = 25;

   // atan(2^-i) in units of 2^-32 of a full turn, rounded
   localparam logic signed [31:0] ATAN_TURN_Q32 [ATAN_LEN] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756, 32'sd42667331,
      32'sd21354465,  32'sd10679838,  32'sd5340245,   32'sd2670163,  32'sd1335087,
      32'sd667544,    32'sd333772,    32'sd166886,    32'sd83443,    32'sd41722,
      32'sd20861,     32'sd10430,     32'sd5215,      32'sd2608,     32'sd1304,
      32'sd652,       32'sd326,       32'sd163,       32'sd81,       32'sd41
   };

   // One classified command between the front and the back
   typedef struct packed {
      logic               match;
      logic [1:0]         quad;
      logic [29:0]        angle;
      logic [15:0]        mag;
      logic signed [10:0] turn;
      logic [3:0]         dribble;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ROTATE,
      BK_MAP,
      BK_SCALE,
      BK_EMIT
   } back_state_type;

endpackage

[rtl/rvcd_front.sv]
module rvcd_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [3:0]                        csr_wr_data,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rvcd_pkg::DATA_IN_W-1:0]    req_tdata,
   output logic                              push_valid,
   input  logic                              push_ready,
   output rvcd_pkg::cmd_type                 push_data
);
   import rvcd_pkg::*;

   logic [3:0]  robot_id_ff;
   logic [3:0]  robot_id_in;
   logic        slot_valid_ff;
   logic        slot_valid_in;
   cmd_type     slot_ff;
   cmd_type     slot_in;
   logic        accept;

   logic [7:0]  header_byte;
   logic [15:0] speed_magnitude;
   logic [15:0] heading;
   logic [15:0] turn_magnitude;
   logic [7:0]  aux_byte;
   logic [32:0] turn_prod;
   logic [9:0]  turn_abs;
   logic        full_turn;

   assign header_byte     = req_tdata[7:0];
   assign speed_magnitude = req_tdata[23:8];
   assign heading         = req_tdata[39:24];
   assign turn_magnitude  = req_tdata[55:40];
   assign aux_byte        = req_tdata[63:56];

   assign req_tready = !slot_valid_ff || push_ready;
   assign accept     = req_tvalid && req_tready;
   assign push_valid = slot_valid_ff;
   assign push_data  = slot_ff;

   assign robot_id_in   = csr_wr_en ? csr_wr_data : robot_id_ff;
   assign slot_valid_in = accept || (slot_valid_ff && !push_ready);

   always_comb begin
      // The phase is heading * 2^32 / 65535, which is the heading repeated in both
      // halves of the word, except that a heading of all ones wraps to zero.
      full_turn = (heading == 16'hFFFF);
      turn_prod = {1'b0, turn_magnitude} * TURN_RECIP;
      turn_abs  = turn_prod[TURN_SHIFT +: 10];

      slot_in.match   = (header_byte[3:0] != 4'd0) &&
                        ((header_byte[3:0] - 4'd1) == robot_id_ff);
      slot_in.quad    = full_turn ? 2'd0 : heading[15:14];
      slot_in.angle   = full_turn ? 30'd0 : {heading[13:0], heading};
      slot_in.mag     = speed_magnitude;
      slot_in.turn    = header_byte[7] ? -$signed({1'b0, turn_abs}) : $signed({1'b0, turn_abs});
      slot_in.dribble = aux_byte[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         robot_id_ff   <= ROBOT_ID_RESET;
         slot_valid_ff <= 1'b0;
      end else begin
         robot_id_ff   <= robot_id_in;
         slot_valid_ff <= slot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff <= slot_in;
      end
   end

endmodule

[rtl/rvcd_queue.sv]
module rvcd_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  rvcd_pkg::cmd_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output rvcd_pkg::cmd_type pop_data
);
   import rvcd_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   cmd_type           entry_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff;
   logic [PtrW-1:0]   wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff;
   logic [PtrW-1:0]   rd_ptr_in;
   logic [CntW-1:0]   count_ff;
   logic [CntW-1:0]   count_in;
   logic              push;
   logic              pop;

   assign push_ready = (count_ff != CntW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/rvcd_back.sv]
module rvcd_back #(
   parameter int TRIG_FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  rvcd_pkg::cmd_type                 pop_data,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rvcd_pkg::DATA_OUT_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser
);
   import rvcd_pkg::*;

   localparam int F   = TRIG_FRAC_BITS;
   localparam int XW  = F + 3;
   localparam int CW  = F + 2;
   localparam int PW  = F + 19;
   localparam int IW  = $clog2(F);
   localparam int AW  = $clog2(ATAN_LEN);

   localparam logic [31:0]          GainInit = CORDIC_GAIN_Q32 >> (32 - F);
   localparam logic [IW-1:0]        LastIter = IW'(F - 1);
   localparam logic signed [XW:0]   UnitWide = (XW + 1)'(2 ** F);
   localparam logic signed [CW-1:0] UnitPos  = CW'(2 ** F);
   localparam logic signed [PW-1:0] TruncBias = PW'((2 ** F) - 1);

   back_state_type        state_ff;
   back_state_type        state_in;
   cmd_type               cmd_ff;
   logic [IW-1:0]         iter_ff;
   logic signed [XW-1:0]  x_ff;
   logic signed [XW-1:0]  x_in;
   logic signed [XW-1:0]  y_ff;
   logic signed [XW-1:0]  y_in;
   logic signed [31:0]    z_ff;
   logic signed [31:0]    z_in;
   logic signed [CW-1:0]  c_ff;
   logic signed [CW-1:0]  c_in;
   logic signed [CW-1:0]  s_ff;
   logic signed [CW-1:0]  s_in;
   logic signed [PW-1:0]  px_ff;
   logic signed [PW-1:0]  px_in;
   logic signed [PW-1:0]  py_ff;
   logic signed [PW-1:0]  py_in;

   logic [16:0]           held_x_ff;
   logic [16:0]           held_y_ff;
   logic [10:0]           held_turn_ff;
   logic [3:0]            held_dribble_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [DATA_OUT_W-1:0] rsp_data_ff;
   logic [DATA_OUT_W-1:0] rsp_data_in;
   logic                  rsp_user_ff;

   logic                  out_free;
   logic                  load_out;
   logic [AW-1:0]         atan_idx;
   logic signed [XW-1:0]  dx;
   logic signed [XW-1:0]  dy;
   logic signed [XW:0]    c_raw;
   logic signed [XW:0]    s_raw;
   logic signed [XW:0]    xe;
   logic signed [XW:0]    ye;
   logic signed [16:0]    mag_s;
   logic signed [PW-1:0]  px_adj;
   logic signed [PW-1:0]  py_adj;
   logic signed [PW-1:0]  px_sh;
   logic signed [PW-1:0]  py_sh;
   logic [16:0]           out_x;
   logic [16:0]           out_y;
   logic [10:0]           out_turn;
   logic [3:0]            out_dribble;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               state_in = pop_data.match ? BK_ROTATE : BK_EMIT;
            end
         end
         BK_ROTATE: begin
            if (iter_ff == LastIter) begin
               state_in = BK_MAP;
            end
         end
         BK_MAP:   state_in = BK_SCALE;
         BK_SCALE: state_in = BK_EMIT;
         BK_EMIT: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default:  state_in = BK_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      pop_ready = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         BK_IDLE: pop_ready = 1'b1;
         BK_EMIT: load_out  = out_free;
         default: begin
            pop_ready = 1'b0;
            load_out  = 1'b0;
         end
      endcase
   end

   // One CORDIC micro-rotation; the residual angle sign picks the direction.
   always_comb begin
      atan_idx = AW'(iter_ff);
      dx = y_ff >>> iter_ff;
      dy = x_ff >>> iter_ff;
      if (!z_ff[31]) begin
         x_in = x_ff - dx;
         y_in = y_ff + dy;
         z_in = z_ff - ATAN_TURN_Q32[atan_idx];
      end else begin
         x_in = x_ff + dx;
         y_in = y_ff - dy;
         z_in = z_ff + ATAN_TURN_Q32[atan_idx];
      end
   end

   // Quadrant fold-back and saturation to plus or minus one
   always_comb begin
      xe = {x_ff[XW-1], x_ff};
      ye = {y_ff[XW-1], y_ff};
      case (cmd_ff.quad)
         2'd0: begin
            c_raw = xe;
            s_raw = ye;
         end
         2'd1: begin
            c_raw = -ye;
            s_raw = xe;
         end
         2'd2: begin
            c_raw = -xe;
            s_raw = -ye;
         end
         default: begin
            c_raw = ye;
            s_raw = -xe;
         end
      endcase
      if (c_raw > UnitWide) begin
         c_in = UnitPos;
      end else if (c_raw < -UnitWide) begin
         c_in = -UnitPos;
      end else begin
         c_in = c_raw[CW-1:0];
      end
      if (s_raw > UnitWide) begin
         s_in = UnitPos;
      end else if (s_raw < -UnitWide) begin
         s_in = -UnitPos;
      end else begin
         s_in = s_raw[CW-1:0];
      end
   end

   always_comb begin
      mag_s = $signed({1'b0, cmd_ff.mag});
      px_in = mag_s * c_ff;
      py_in = mag_s * s_ff;
      // Adding the bias to negative products makes the shift truncate toward zero.
      px_adj = px_ff + (px_ff[PW-1] ? TruncBias : '0);
      py_adj = py_ff + (py_ff[PW-1] ? TruncBias : '0);
      px_sh  = px_adj >>> F;
      py_sh  = py_adj >>> F;
   end

   always_comb begin
      if (cmd_ff.match) begin
         out_x       = px_sh[16:0];
         out_y       = py_sh[16:0];
         out_turn    = cmd_ff.turn;
         out_dribble = cmd_ff.dribble;
      end else begin
         out_x       = held_x_ff;
         out_y       = held_y_ff;
         out_turn    = held_turn_ff;
         out_dribble = held_dribble_ff;
      end
      rsp_data_in  = {7'd0, out_dribble, out_turn, out_y, out_x};
      rsp_valid_in = load_out || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= BK_IDLE;
         rsp_valid_ff    <= 1'b0;
         held_x_ff       <= '0;
         held_y_ff       <= '0;
         held_turn_ff    <= '0;
         held_dribble_ff <= DRIBBLE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load_out && cmd_ff.match) begin
            held_x_ff       <= out_x;
            held_y_ff       <= out_y;
            held_turn_ff    <= out_turn;
            held_dribble_ff <= out_dribble;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               cmd_ff  <= pop_data;
               x_ff    <= $signed(XW'(GainInit));
               y_ff    <= '0;
               z_ff    <= $signed({2'b00, pop_data.angle});
               iter_ff <= '0;
            end
         end
         BK_ROTATE: begin
            x_ff    <= x_in;
            y_ff    <= y_in;
            z_ff    <= z_in;
            iter_ff <= iter_ff + 1'b1;
         end
         BK_MAP: begin
            c_ff <= c_in;
            s_ff <= s_in;
         end
         BK_SCALE: begin
            px_ff <= px_in;
            py_ff <= py_in;
         end
         default: begin
         end
      endcase
      if (load_out) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= cmd_ff.match;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[rtl/robot_velocity_command_decoder.sv]
// Robot velocity command decoder.
// The req channel takes one decoded command packet per transfer; the rsp channel
// returns exactly one result per packet, in order: the held velocity command, with
// rsp_tuser high when this packet's id matched and the command was replaced.
// The csr port sets the robot id; write it only while no packet is in flight.
// A packet passes a front register that checks the id and scales the turn speed,
// then a queue of QUEUE_DEPTH entries, then the back end. The back end runs an
// iterative CORDIC, one micro-rotation per cycle, and takes no new packet until
// the last one is emitted, which sets the sustained rate. A matching packet passes
// the rotate, map, scale and emit states; a packet for another robot goes from
// idle straight to emit. Either way, the result reaches rsp_tvalid through the
// output register, after any wait in the queue.
// The result sits in an output register: while the receiver stalls, the back end
// waits with the next result, the queue keeps filling and req_tready drops only
// once the queue and front register are full.
// Reset clears the pipeline, sets the robot id to 1 and the held command to zero
// speeds with dribble power 3.
module robot_velocity_command_decoder #(
   parameter int TRIG_FRAC_BITS = 16,
   parameter int QUEUE_DEPTH    = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,      // robot_id
   input  logic        req_tvalid,
   output logic        req_tready,
   // header_byte[7:0], speed_magnitude[23:8], heading[39:24],
   // turn_magnitude[55:40], aux_byte[63:56]
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // speed_x[16:0], speed_y[33:17], speed_turn[44:34], dribbler_drive[48:45], zeros above
   output logic [55:0] rsp_tdata,
   output logic        rsp_tuser         // matched
);
   import rvcd_pkg::*;

   logic    push_valid;
   logic    push_ready;
   cmd_type push_data;
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_data;

   rvcd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   rvcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rvcd_back #(
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   a_rsp_idle_after_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_turn_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[44:34]) <= 11'sd524 &&
                      $signed(rsp_tdata[44:34]) >= -11'sd524))
      else $error("turn speed outside the scaled range");

   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[16:0] != 17'h10000 && rsp_tdata[33:17] != 17'h10000))
      else $error("speed beyond the magnitude range");

   a_push_fed_from_front: assert property (@(posedge clock) disable iff (reset)
      (push_valid && !push_ready) |=> push_valid)
      else $error("front slot lost while the queue was full");

endmodule
